// File: design/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

  // Hue rotation and sector bounds on the rotated hue
  localparam logic [7:0] HUE_OFFSET = 8'd43;
  localparam logic [7:0] SEC_B1     = 8'd43;
  localparam logic [7:0] SEC_B2     = 8'd85;
  localparam logic [7:0] SEC_B3     = 8'd128;
  localparam logic [7:0] SEC_B4     = 8'd171;
  localparam logic [7:0] SEC_B5     = 8'd213;
  localparam logic [7:0] FULL       = 8'd255;

  // Saturation above this gets one added to its weight
  localparam logic [7:0] SAT_KNEE   = 8'd128;

  // Ramp x*255/43 as a multiply by a scaled reciprocal; exact for x below 186
  localparam int unsigned RAMP_X_W     = 7;
  localparam int unsigned RECIP_W      = 23;
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam logic [RECIP_W-1:0] RAMP_RECIP = 23'd6218430;
  localparam int unsigned RAMP_Q_W     = 9;

  // Saturation weight spans 0..256
  localparam int unsigned WEIGHT_W = 9;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef enum logic [2:0] {
    SEC_RED_UP_GREEN_DN,
    SEC_RED_BLUE_UP,
    SEC_BLUE_RED_DN,
    SEC_BLUE_GREEN_UP,
    SEC_GREEN_BLUE_DN,
    SEC_GREEN_RED_UP
  } sector_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Pixel handed from the sector stages to the scaling stages
  typedef struct packed {
    rgb_t                color;
    logic [WEIGHT_W-1:0] weight;
    logic [7:0]          brightness;
  } chroma_t;

endpackage

// File: design/hsv2rgb_sector.sv
// Hue sector decode and ramp generation: two register stages.
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output chroma_t    out_data
);

  logic                     a_vld_r;
  sector_t                  a_sec_r, a_sec_nxt;
  logic [RAMP_X_W-1:0]      a_x_r, a_x_nxt;
  logic [WEIGHT_W-1:0]      a_w_r, a_w_nxt;
  logic [7:0]               a_bri_r;
  logic                     b_vld_r;
  chroma_t                  b_data_r, b_data_nxt;
  logic                     a_rdy, b_rdy;
  logic [7:0]               h_rot;
  logic [7:0]               x_full;
  logic [RAMP_X_W+RECIP_W-1:0] prod;
  logic [RAMP_Q_W-1:0]      q;

  assign b_rdy    = !b_vld_r || out_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // Rotate hue, pick sector and ramp operand, form saturation weight
  always_comb begin
    h_rot = in_hue - HUE_OFFSET;
    priority if (h_rot < SEC_B1) begin
      a_sec_nxt = SEC_RED_UP_GREEN_DN;
      x_full    = h_rot;
    end else if (h_rot < SEC_B2) begin
      a_sec_nxt = SEC_RED_BLUE_UP;
      x_full    = h_rot;
    end else if (h_rot < SEC_B3) begin
      a_sec_nxt = SEC_BLUE_RED_DN;
      x_full    = SEC_B3 - h_rot;
    end else if (h_rot < SEC_B4) begin
      a_sec_nxt = SEC_BLUE_GREEN_UP;
      x_full    = h_rot - SEC_B3;
    end else if (h_rot < SEC_B5) begin
      a_sec_nxt = SEC_GREEN_BLUE_DN;
      x_full    = SEC_B5 - h_rot;
    end else begin
      a_sec_nxt = SEC_GREEN_RED_UP;
      x_full    = h_rot - SEC_B5;
    end
    a_x_nxt = x_full[RAMP_X_W-1:0];
    if (in_saturation > SAT_KNEE) begin
      a_w_nxt = {1'b0, in_saturation} + WEIGHT_W'(1);
    end else begin
      a_w_nxt = {1'b0, in_saturation};
    end
  end

  // Ramp value and channel assignment per sector
  always_comb begin
    prod = RAMP_X_W'(a_x_r) * RAMP_RECIP;
    q    = prod[RECIP_SHIFT +: RAMP_Q_W];
    b_data_nxt.weight     = a_w_r;
    b_data_nxt.brightness = a_bri_r;
    b_data_nxt.color      = '0;
    unique case (a_sec_r)
      SEC_RED_UP_GREEN_DN: begin
        b_data_nxt.color.red   = FULL;
        b_data_nxt.color.green = FULL - q[7:0];
      end
      SEC_RED_BLUE_UP: begin
        b_data_nxt.color.red   = FULL;
        b_data_nxt.color.blue  = 8'(q - {1'b0, FULL});
      end
      SEC_BLUE_RED_DN: begin
        b_data_nxt.color.blue  = FULL;
        b_data_nxt.color.red   = q[7:0];
      end
      SEC_BLUE_GREEN_UP: begin
        b_data_nxt.color.blue  = FULL;
        b_data_nxt.color.green = q[7:0];
      end
      SEC_GREEN_BLUE_DN: begin
        b_data_nxt.color.green = FULL;
        b_data_nxt.color.blue  = q[7:0];
      end
      SEC_GREEN_RED_UP: begin
        b_data_nxt.color.green = FULL;
        b_data_nxt.color.red   = q[7:0];
      end
      default: begin
        b_data_nxt.color = '0;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
    end
  end

  // Load payload on each stage transfer
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_sec_r <= a_sec_nxt;
      a_x_r   <= a_x_nxt;
      a_w_r   <= a_w_nxt;
      a_bri_r <= in_brightness;
    end
    if (b_rdy && a_vld_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_data  = b_data_r;

endmodule

// File: design/hsv2rgb_scale.sv
// Brightness scaling and saturation blend toward white: two register stages.
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  chroma_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output rgb_t    out_data
);

  logic                c_vld_r;
  rgb_t                c_rgb_r, c_rgb_nxt;
  logic [WEIGHT_W-1:0] c_w_r;
  logic [15:0]         c_white_r, c_white_nxt;
  logic                d_vld_r;
  rgb_t                d_rgb_r, d_rgb_nxt;
  logic                c_rdy, d_rdy;
  logic [15:0]         pr, pg, pb;
  logic [16:0]         mr, mg, mb;

  assign d_rdy    = !d_vld_r || out_ready;
  assign c_rdy    = !c_vld_r || d_rdy;
  assign in_ready = c_rdy;

  // Scale each channel by brightness; precompute the white share
  always_comb begin
    pr = in_data.color.red   * in_data.brightness;
    pg = in_data.color.green * in_data.brightness;
    pb = in_data.color.blue  * in_data.brightness;
    c_rgb_nxt.red   = pr[15:8];
    c_rgb_nxt.green = pg[15:8];
    c_rgb_nxt.blue  = pb[15:8];
    c_white_nxt     = 16'(FULL) * (16'(WEIGHT_ONE) - 16'(in_data.weight));
  end

  // Blend toward white by the saturation weight
  always_comb begin
    mr = 17'(c_rgb_r.red)   * 17'(c_w_r) + {1'b0, c_white_r};
    mg = 17'(c_rgb_r.green) * 17'(c_w_r) + {1'b0, c_white_r};
    mb = 17'(c_rgb_r.blue)  * 17'(c_w_r) + {1'b0, c_white_r};
    d_rgb_nxt.red   = mr[15:8];
    d_rgb_nxt.green = mg[15:8];
    d_rgb_nxt.blue  = mb[15:8];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      if (c_rdy) c_vld_r <= in_valid;
      if (d_rdy) d_vld_r <= c_vld_r;
    end
  end

  // Load payload on each stage transfer
  always_ff @(posedge clk) begin
    if (c_rdy && in_valid) begin
      c_rgb_r   <= c_rgb_nxt;
      c_w_r     <= in_data.weight;
      c_white_r <= c_white_nxt;
    end
    if (d_rdy && c_vld_r) begin
      d_rgb_r <= d_rgb_nxt;
    end
  end

  assign out_valid = d_vld_r;
  assign out_data  = d_rgb_r;

endmodule

// File: design/hsv_to_rgb_8bit.sv
// Top level of the 8-bit HSV to RGB pixel converter.
// Converts one pixel per clock while the output is not stalled, from 8-bit
// hue, saturation and brightness to 8-bit red, green and blue. The pipeline is
// four register stages deep; it takes a new pixel every cycle unless out_tready
// holds it back, and each stage holds its item while the stage after it is
// stalled, so bubbles close up and nothing is dropped or repeated. The
// stages are: hue sector decode, ramp by reciprocal multiply, brightness
// scaling, and blend toward white by saturation. Zero saturation gives white.
module hsv_to_rgb_8bit
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic    mid_valid;
  logic    mid_ready;
  chroma_t mid_data;
  rgb_t    rgb;

  hsv2rgb_sector u_sector (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_hue        (in_tdata[7:0]),
    .in_saturation (in_tdata[15:8]),
    .in_brightness (in_tdata[23:16]),
    .out_valid     (mid_valid),
    .out_ready     (mid_ready),
    .out_data      (mid_data)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rgb)
  );

  // Pack channels, red lowest
  assign out_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule
